// ===== src/msp_pkg.sv =====
// Shared types, constants and helper functions of the mecanum step pulse generator.
`default_nettype none
package msp_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int ACC_W      = 19;
    localparam int PROD_W     = 27;
    localparam int SPEED_W    = 28;
    localparam int MAG_W      = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // input mode codes
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_CMD  = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_WEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MICROSTEP   = 3'd5;

    // register reset values
    localparam logic [9:0]  RST_WEIGHT      = 10'd1;
    localparam logic [15:0] RST_LOOP_PERIOD = 16'd100;
    localparam logic [15:0] RST_FULL_SCALE  = 16'd1000;
    localparam logic [2:0]  RST_MICROSTEP   = 3'd0;

    // microstep resolution codes
    localparam logic [2:0] MS_HALF      = 3'd1;
    localparam logic [2:0] MS_QUARTER   = 3'd2;
    localparam logic [2:0] MS_EIGHTH    = 3'd3;
    localparam logic [2:0] MS_SIXTEENTH = 3'd4;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CMD  = 2'd1,
        OP_STOP = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] straight;
        logic signed [15:0] side;
        logic signed [15:0] rotate;
    } q_item_t;

    typedef struct packed {
        logic [9:0]  fwd_weight;
        logic [9:0]  lat_weight;
        logic [9:0]  spin_weight;
        logic [15:0] loop_period;
        logic [15:0] full_scale;
        logic [2:0]  microstep_code;
    } cfg_t;

    // MS3..MS1 pin levels for a resolution code
    function automatic logic [2:0] ms_pins(input logic [2:0] code);
        logic [2:0] pins;
        case (code)
            MS_HALF:      pins = 3'b001;
            MS_QUARTER:   pins = 3'b010;
            MS_EIGHTH:    pins = 3'b011;
            MS_SIXTEENTH: pins = 3'b111;
            default:      pins = 3'b000;
        endcase
        return pins;
    endfunction

endpackage
`default_nettype wire

// ===== src/msp_if.sv =====
// Channel interfaces: command/tick input and pin-state result output.
`default_nettype none
interface msp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] straight;
    logic signed [15:0] side;
    logic signed [15:0] rotate;

    modport source (output valid, output mode, output straight, output side, output rotate,
                    input ready);
    modport sink   (input valid, input mode, input straight, input side, input rotate,
                    output ready);
endinterface

interface msp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] step_pulses;
    logic [3:0] direction_bits;
    logic       driver_enable;
    logic [2:0] microstep_pins;

    modport source (output valid, output step_pulses, output direction_bits,
                    output driver_enable, output microstep_pins, input ready);
    modport sink   (input valid, input step_pulses, input direction_bits,
                    input driver_enable, input microstep_pins, output ready);
endinterface
`default_nettype wire

// ===== src/msp_front.sv =====
// Front end: accept input transactions, classify the mode, hold them in a two-entry queue.
`default_nettype none
module msp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    msp_in_if.sink             in_ch,
    output msp_pkg::q_item_t   q_item,
    output logic               q_valid,
    input  wire logic          q_pop
);

    msp_pkg::q_item_t item_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;
    msp_pkg::q_item_t new_item;

    always_comb
    begin
        case (in_ch.mode)
            msp_pkg::MODE_TICK: new_item.op = msp_pkg::OP_TICK;
            msp_pkg::MODE_CMD:  new_item.op = msp_pkg::OP_CMD;
            msp_pkg::MODE_STOP: new_item.op = msp_pkg::OP_STOP;
            default:            new_item.op = msp_pkg::OP_NOP;
        endcase
        new_item.straight = in_ch.straight;
        new_item.side     = in_ch.side;
        new_item.rotate   = in_ch.rotate;
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign q_valid     = (count_reg != 2'd0);
    assign q_item      = item_reg[rd_ptr_reg];
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/msp_back.sv =====
// Back end: wheel mixing, rate division, accumulator stepping and the result register.
`default_nettype none
module msp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msp_pkg::cfg_t    cfg,
    input  wire msp_pkg::q_item_t q_item,
    input  wire logic             q_valid,
    output logic                  q_pop,
    msp_out_if.source             out_ch
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MIX    = 7'b0000010,
        ST_SPEED  = 7'b0000100,
        ST_SCALE  = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_UPDATE = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    localparam int NW    = msp_pkg::NUM_WHEELS;
    localparam int ACC_W = msp_pkg::ACC_W;

    state_t state_reg, state_next;

    // wheel state
    logic signed [ACC_W-1:0] acc_reg  [NW];
    logic signed [ACC_W-1:0] acc_next [NW];
    logic [15:0]             rate_reg  [NW];
    logic [15:0]             rate_next [NW];
    logic [NW-1:0]           dir_reg, dir_next;
    logic                    running_reg, running_next;

    // command datapath
    logic signed [15:0]                  cmd_straight_reg, cmd_straight_next;
    logic signed [15:0]                  cmd_side_reg, cmd_side_next;
    logic signed [15:0]                  cmd_rotate_reg, cmd_rotate_next;
    logic signed [msp_pkg::PROD_W-1:0]   s_reg, s_next;
    logic signed [msp_pkg::PROD_W-1:0]   d_reg, d_next;
    logic signed [msp_pkg::PROD_W-1:0]   r_reg, r_next;
    logic [1:0]                          wheel_reg, wheel_next;
    logic [msp_pkg::MAG_W-1:0]           mag_reg, mag_next;
    logic                                ndir_reg, ndir_next;
    logic                                sat_reg, sat_next;
    logic                                zero_reg, zero_next;
    logic [15:0]                         rem_reg, rem_next;
    logic [15:0]                         quo_reg, quo_next;
    logic [3:0]                          cnt_reg, cnt_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_steps_reg, out_steps_next;
    logic [3:0] out_dirs_reg, out_dirs_next;
    logic       out_en_reg, out_en_next;
    logic [2:0] out_ms_reg, out_ms_next;
    logic       out_free;

    // combinational helpers
    logic signed [msp_pkg::SPEED_W-1:0] sx, dx, rx, speed;
    logic [31:0]                        prod;
    logic [16:0]                        shifted;
    logic                               ge;
    logic [16:0]                        diff;
    logic [15:0]                        rate_new;
    logic [NW-1:0]                      tick_steps;
    logic signed [ACC_W-1:0]            tick_acc [NW];

    assign out_free = !out_valid_reg || out_ch.ready;

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.step_pulses    = out_steps_reg;
    assign out_ch.direction_bits = out_dirs_reg;
    assign out_ch.driver_enable  = out_en_reg;
    assign out_ch.microstep_pins = out_ms_reg;

    // speed of the wheel under work: side adds on wheels 0 and 3, rotate on 2 and 3
    always_comb
    begin
        sx = {s_reg[msp_pkg::PROD_W-1], s_reg};
        dx = {d_reg[msp_pkg::PROD_W-1], d_reg};
        rx = {r_reg[msp_pkg::PROD_W-1], r_reg};
        speed = sx + (((wheel_reg == 2'd0) || (wheel_reg == 2'd3)) ? dx : -dx)
                   + (wheel_reg[1] ? rx : -rx);
    end

    assign prod    = {16'd0, mag_reg[15:0]} * {16'd0, cfg.loop_period};
    assign shifted = {rem_reg, quo_reg[15]};
    assign ge      = (shifted >= {1'b0, cfg.full_scale});
    assign diff    = shifted - {1'b0, cfg.full_scale};
    assign rate_new = zero_reg ? 16'd0 : (sat_reg ? cfg.loop_period : quo_reg);

    // tick update of every wheel
    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            tick_steps[i] = !acc_reg[i][ACC_W-1] && (acc_reg[i] != '0);
            tick_acc[i]   = acc_reg[i]
                          - (tick_steps[i] ? {2'b00, cfg.loop_period, 1'b0} : {ACC_W{1'b0}})
                          + {2'b00, rate_reg[i], 1'b0};
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        acc_next          = acc_reg;
        rate_next         = rate_reg;
        dir_next          = dir_reg;
        running_next      = running_reg;
        cmd_straight_next = cmd_straight_reg;
        cmd_side_next     = cmd_side_reg;
        cmd_rotate_next   = cmd_rotate_reg;
        s_next            = s_reg;
        d_next            = d_reg;
        r_next            = r_reg;
        wheel_next        = wheel_reg;
        mag_next          = mag_reg;
        ndir_next         = ndir_reg;
        sat_next          = sat_reg;
        zero_next         = zero_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_steps_next    = out_steps_reg;
        out_dirs_next     = out_dirs_reg;
        out_en_next       = out_en_reg;
        out_ms_next       = out_ms_reg;
        q_pop             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        msp_pkg::OP_CMD:
                        begin
                            q_pop             = 1'b1;
                            cmd_straight_next = q_item.straight;
                            cmd_side_next     = q_item.side;
                            cmd_rotate_next   = q_item.rotate;
                            wheel_next        = 2'd0;
                            state_next        = ST_MIX;
                        end
                        msp_pkg::OP_TICK:
                        begin
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                out_dirs_next  = dir_reg;
                                out_en_next    = running_reg;
                                out_ms_next    = msp_pkg::ms_pins(cfg.microstep_code);
                                out_steps_next = running_reg ? tick_steps : 4'd0;
                                if (running_reg)
                                begin
                                    acc_next = tick_acc;
                                end
                            end
                        end
                        msp_pkg::OP_STOP:
                        begin
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                for (int i = 0; i < NW; i++)
                                begin
                                    acc_next[i]  = '0;
                                    rate_next[i] = '0;
                                end
                                dir_next       = '0;
                                running_next   = 1'b0;
                                out_valid_next = 1'b1;
                                out_steps_next = 4'd0;
                                out_dirs_next  = '0;
                                out_en_next    = 1'b0;
                                out_ms_next    = msp_pkg::ms_pins(cfg.microstep_code);
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                out_steps_next = 4'd0;
                                out_dirs_next  = dir_reg;
                                out_en_next    = running_reg;
                                out_ms_next    = msp_pkg::ms_pins(cfg.microstep_code);
                            end
                        end
                    endcase
                end
            end

            ST_MIX:
            begin
                s_next = {{17{1'b0}}, cfg.fwd_weight}
                       * {{11{cmd_straight_reg[15]}}, cmd_straight_reg};
                d_next = {{17{1'b0}}, cfg.lat_weight}
                       * {{11{cmd_side_reg[15]}}, cmd_side_reg};
                r_next = {{17{1'b0}}, cfg.spin_weight}
                       * {{11{cmd_rotate_reg[15]}}, cmd_rotate_reg};
                state_next = ST_SPEED;
            end

            ST_SPEED:
            begin
                ndir_next = speed[msp_pkg::SPEED_W-1] || (speed == '0);
                mag_next  = speed[msp_pkg::SPEED_W-1] ? msp_pkg::MAG_W'(-speed)
                                                      : msp_pkg::MAG_W'(speed);
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                // a nonzero magnitude at or above full scale saturates at loop_period
                sat_next  = (cfg.full_scale == 16'd0) || (mag_reg >= {11'd0, cfg.full_scale});
                zero_next = (mag_reg == '0);
                rem_next  = prod[31:16];
                quo_next  = prod[15:0];
                cnt_next  = 4'd0;
                if ((cfg.full_scale == 16'd0) || (mag_reg >= {11'd0, cfg.full_scale})
                    || (mag_reg == '0))
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = ge ? diff[15:0] : shifted[15:0];
                quo_next = {quo_reg[14:0], ge};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                rate_next[wheel_reg] = rate_new;
                if (ndir_reg != dir_reg[wheel_reg])
                begin
                    dir_next[wheel_reg] = ndir_reg;
                    acc_next[wheel_reg] = {2'b00, rate_new, 1'b0} - {3'b000, cfg.loop_period};
                end
                if (wheel_reg == 2'd3)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    wheel_next = wheel_reg + 2'd1;
                    state_next = ST_SPEED;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    running_next   = 1'b1;
                    out_valid_next = 1'b1;
                    out_steps_next = 4'd0;
                    out_dirs_next  = dir_reg;
                    out_en_next    = 1'b1;
                    out_ms_next    = msp_pkg::ms_pins(cfg.microstep_code);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NW; i++)
            begin
                acc_reg[i]  <= '0;
                rate_reg[i] <= '0;
            end
            dir_reg       <= '0;
            running_reg   <= 1'b0;
            wheel_reg     <= 2'd0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            rate_reg      <= rate_next;
            dir_reg       <= dir_next;
            running_reg   <= running_next;
            wheel_reg     <= wheel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_straight_reg <= cmd_straight_next;
        cmd_side_reg     <= cmd_side_next;
        cmd_rotate_reg   <= cmd_rotate_next;
        s_reg            <= s_next;
        d_reg            <= d_next;
        r_reg            <= r_next;
        mag_reg          <= mag_next;
        ndir_reg         <= ndir_next;
        sat_reg          <= sat_next;
        zero_reg         <= zero_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        out_steps_reg    <= out_steps_next;
        out_dirs_reg     <= out_dirs_next;
        out_en_reg       <= out_en_next;
        out_ms_reg       <= out_ms_next;
    end

endmodule
`default_nettype wire

// ===== src/mecanum_step_pulse_generator_unit.sv =====
// Top level of the four-wheel mecanum step pulse generator.
`default_nettype none
// Four-wheel mecanum stepper driver. Each input transaction carries a mode: a tick
// advances the per-wheel step accumulators and reports which wheels step; a motion
// command mixes straight, side and rotate into four wheel speeds, sets direction pins
// and step rates; a stop clears all wheel state and drops driver_enable. Every input
// transaction yields exactly one output transaction with the step pulses, direction
// pins, enable and microstep pins. A front end classifies inputs into a two-entry
// queue, so the upstream side keeps moving while the back end works or the output
// stalls, until the queue is full. Ticks, stops and ignored modes are handled in the
// idle state, so they sustain one transaction per cycle once the queue is primed and
// while the output is not stalled. A motion command pops the item, forms the three
// coefficient multiplies, then per wheel computes the speed and the magnitude times
// loop_period product, runs the shared radix-2 rate divider (skipped when the rate
// saturates or is zero) and writes the wheel, and finally posts the result. Write
// configuration only while no transaction is in flight; writes to indexes beyond
// microstep_code are dropped.
module mecanum_step_pulse_generator_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    msp_in_if.sink                               in_ch,
    msp_out_if.source                            out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    msp_pkg::cfg_t    cfg_reg, cfg_next;
    msp_pkg::q_item_t q_item;
    logic             q_valid;
    logic             q_pop;

    // register file: hold values until written
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                msp_pkg::CFG_FWD_WEIGHT:  cfg_next.fwd_weight     = cfg_data[9:0];
                msp_pkg::CFG_LAT_WEIGHT:  cfg_next.lat_weight     = cfg_data[9:0];
                msp_pkg::CFG_SPIN_WEIGHT: cfg_next.spin_weight    = cfg_data[9:0];
                msp_pkg::CFG_LOOP_PERIOD: cfg_next.loop_period    = cfg_data;
                msp_pkg::CFG_FULL_SCALE:  cfg_next.full_scale     = cfg_data;
                msp_pkg::CFG_MICROSTEP:   cfg_next.microstep_code = cfg_data[2:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fwd_weight     <= msp_pkg::RST_WEIGHT;
            cfg_reg.lat_weight     <= msp_pkg::RST_WEIGHT;
            cfg_reg.spin_weight    <= msp_pkg::RST_WEIGHT;
            cfg_reg.loop_period    <= msp_pkg::RST_LOOP_PERIOD;
            cfg_reg.full_scale     <= msp_pkg::RST_FULL_SCALE;
            cfg_reg.microstep_code <= msp_pkg::RST_MICROSTEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accept and classify, queue toward the back end
    msp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // back end: mixing, rate division, stepping, result register
    msp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule
`default_nettype wire
